// File: hw/rtl/qrc_pkg.sv
// shared constants, register codes and the arctangent table of the rectangle check
package qrc_pkg;

   localparam int COORD_BITS_DEF = 11;

   // configuration register widths, reset values and indexes
   localparam int RATIO_TARGET_W = 10;
   localparam int RATIO_TOL_W    = 8;
   localparam int ANGLE_TOL_W    = 6;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 10;

   localparam logic [RATIO_TARGET_W-1:0] RATIO_TARGET_RST = 10'd205;
   localparam logic [RATIO_TOL_W-1:0]    RATIO_TOL_RST    = 8'd26;
   localparam logic [ANGLE_TOL_W-1:0]    ANGLE_TOL_RST    = 6'd10;

   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_TARGET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_TOL    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_TOL    = 2'd2;

   // angles, degrees q.8
   localparam int ANGLE_W = 16;
   localparam logic [ANGLE_W-1:0] RIGHT_Q8    = 16'd23040;
   localparam logic [ANGLE_W-1:0] STRAIGHT_Q8 = 16'd46080;

   // cordic datapath
   localparam int CORDIC_STEPS = 16;
   localparam int NORM_W       = 41;   // normalised magnitude, top bit is 2^40
   localparam int XY_W         = 45;   // signed rotation registers
   localparam int Z_W          = 26;   // signed angle accumulator, 1/65536 degree
   localparam int ATAN_W       = 22;
   localparam logic [Z_W-1:0] Z_RIGHT = 26'd5898240;

   localparam logic [ATAN_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117304,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115
   };

endpackage

// File: hw/rtl/quad_rectangle_check_unit.sv
// rectangle check of a quadrilateral: side ratio and three corner angles, fully pipelined
//
// Takes one quadrilateral word (four corners, COORD_BITS each axis) per clock unless req_stall is
// high and returns one result word per input, in order. The pipeline stages are difference,
// multiply, sum, ratio multiply and angle set-up, two normalisation stages, sixteen cordic
// rotation stages (one per step, 45 bit adds and subtracts in each), rounding and the final
// checks. Throughput is one word per cycle when the result side does not stall; every stage
// has its own valid bit and loads whenever it is empty or its content moves on,
// so bubbles close up and the input keeps being accepted while a finished result waits on
// rsp_stall, until the pipeline is full. The side ratio |p0-p1|/|p2-p1| is compared exactly on
// squared lengths against (target +/- tolerance)/256; corner angles at p1, p2 and p3 come out
// as atan2(|cross|, dot) in degrees times 256, and a corner with a zero length side reads as
// 90 degrees. Registers (index: 0 ratio target, 1 ratio tolerance, 2 angle tolerance in whole
// degrees) are written through the csr port, always ready, and should only change while idle.
module quad_rectangle_check_unit
   import qrc_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COORD_BITS-1:0]     req_p0_x,
   input  logic [COORD_BITS-1:0]     req_p0_y,
   input  logic [COORD_BITS-1:0]     req_p1_x,
   input  logic [COORD_BITS-1:0]     req_p1_y,
   input  logic [COORD_BITS-1:0]     req_p2_x,
   input  logic [COORD_BITS-1:0]     req_p2_y,
   input  logic [COORD_BITS-1:0]     req_p3_x,
   input  logic [COORD_BITS-1:0]     req_p3_y,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_rect,
   output logic                      rsp_ratio_ok,
   output logic [ANGLE_W-1:0]        rsp_angle_at_p1,
   output logic [ANGLE_W-1:0]        rsp_angle_at_p2,
   output logic [ANGLE_W-1:0]        rsp_angle_at_p3,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   // datapath widths that follow from the coordinate width
   localparam int DW  = COORD_BITS + 1;       // signed coordinate difference
   localparam int PW  = 2 * COORD_BITS + 2;   // signed product
   localparam int SW  = 2 * COORD_BITS + 3;   // signed dot / cross
   localparam int LW  = 2 * COORD_BITS + 2;   // unsigned squared length
   localparam int MW  = 2 * COORD_BITS + 2;   // unsigned magnitude fed to the normaliser
   localparam int HW  = RATIO_TARGET_W + 1;   // target + tolerance
   localparam int H2W = 2 * HW;               // bound squared
   localparam int RW  = LW + H2W;             // ratio compare width

   // stage numbers
   localparam int ST_DIFF = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_PREP = 3;
   localparam int ST_NRM1 = 4;
   localparam int ST_NRM2 = 5;
   localparam int ST_ROT0 = 6;
   localparam int ST_ANG  = ST_ROT0 + CORDIC_STEPS;
   localparam int ST_OUT  = ST_ANG + 1;
   localparam int NS      = ST_OUT + 1;

   // ---------------------------------------------------------------- configuration registers
   logic [RATIO_TARGET_W-1:0] ratio_target_ff;
   logic [RATIO_TOL_W-1:0]    ratio_tol_ff;
   logic [ANGLE_TOL_W-1:0]    angle_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_target_ff <= RATIO_TARGET_RST;
         ratio_tol_ff    <= RATIO_TOL_RST;
         angle_tol_ff    <= ANGLE_TOL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RATIO_TARGET: ratio_target_ff <= csr_wdata[RATIO_TARGET_W-1:0];
            CSR_RATIO_TOL:    ratio_tol_ff    <= csr_wdata[RATIO_TOL_W-1:0];
            CSR_ANGLE_TOL:    angle_tol_ff    <= csr_wdata[ANGLE_TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline flow control
   // a stage loads when it is empty or its word moves on in the same cycle
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] ld;

   always_comb begin
      ld[NS-1] = !v_ff[NS-1] || !rsp_stall;
      for (int k = NS - 2; k >= 0; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
      v_in[0] = ld[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = ld[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !ld[0];
   assign rsp_valid = v_ff[NS-1];

   // ---------------------------------------------------------------- difference stage
   // lane 0: corner p1 (u = p2-p1, w = p0-p1), lane 1: p2, lane 2: p3
   logic signed [DW-1:0] ux_ff [3];
   logic signed [DW-1:0] uy_ff [3];
   logic signed [DW-1:0] wx_ff [3];
   logic signed [DW-1:0] wy_ff [3];
   logic signed [DW-1:0] ux_in [3];
   logic signed [DW-1:0] uy_in [3];
   logic signed [DW-1:0] wx_in [3];
   logic signed [DW-1:0] wy_in [3];

   function automatic logic signed [DW-1:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   always_comb begin
      ux_in[0] = coord_diff(req_p2_x, req_p1_x);
      uy_in[0] = coord_diff(req_p2_y, req_p1_y);
      wx_in[0] = coord_diff(req_p0_x, req_p1_x);
      wy_in[0] = coord_diff(req_p0_y, req_p1_y);
      ux_in[1] = coord_diff(req_p3_x, req_p2_x);
      uy_in[1] = coord_diff(req_p3_y, req_p2_y);
      wx_in[1] = coord_diff(req_p1_x, req_p2_x);
      wy_in[1] = coord_diff(req_p1_y, req_p2_y);
      ux_in[2] = coord_diff(req_p0_x, req_p3_x);
      uy_in[2] = coord_diff(req_p0_y, req_p3_y);
      wx_in[2] = coord_diff(req_p2_x, req_p3_x);
      wy_in[2] = coord_diff(req_p2_y, req_p3_y);
   end

   always_ff @(posedge clock) begin
      if (ld[ST_DIFF]) begin
         ux_ff <= ux_in;
         uy_ff <= uy_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   // ---------------------------------------------------------------- multiply stage
   logic signed [PW-1:0] pa_ff [3];   // ux*wx
   logic signed [PW-1:0] pb_ff [3];   // uy*wy
   logic signed [PW-1:0] pc_ff [3];   // ux*wy
   logic signed [PW-1:0] pd_ff [3];   // uy*wx
   logic signed [PW-1:0] pa_in [3];
   logic signed [PW-1:0] pb_in [3];
   logic signed [PW-1:0] pc_in [3];
   logic signed [PW-1:0] pd_in [3];
   logic signed [PW-1:0] la_x_ff, la_y_ff, lb_x_ff, lb_y_ff;
   logic signed [PW-1:0] la_x_in, la_y_in, lb_x_in, lb_y_in;
   logic [H2W-1:0]       hi2_m_ff, lo2_m_ff, hi2_m_in, lo2_m_in;
   logic                 lo_en_m_ff, lo_en_m_in;
   logic [2:0]           zf_in;
   logic [HW-1:0]        hi_sum;
   logic [RATIO_TARGET_W-1:0] lo_diff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         pa_in[l] = PW'(ux_ff[l]) * PW'(wx_ff[l]);
         pb_in[l] = PW'(uy_ff[l]) * PW'(wy_ff[l]);
         pc_in[l] = PW'(ux_ff[l]) * PW'(wy_ff[l]);
         pd_in[l] = PW'(uy_ff[l]) * PW'(wx_ff[l]);
         zf_in[l] = ((ux_ff[l] == '0) && (uy_ff[l] == '0)) ||
                    ((wx_ff[l] == '0) && (wy_ff[l] == '0));
      end
      // side a = p0-p1 (w of corner p1), side b = p2-p1 (u of corner p1)
      la_x_in = PW'(wx_ff[0]) * PW'(wx_ff[0]);
      la_y_in = PW'(wy_ff[0]) * PW'(wy_ff[0]);
      lb_x_in = PW'(ux_ff[0]) * PW'(ux_ff[0]);
      lb_y_in = PW'(uy_ff[0]) * PW'(uy_ff[0]);
      // ratio bounds, squared so the compare stays on integers
      hi_sum     = HW'(ratio_target_ff) + HW'(ratio_tol_ff);
      lo_en_m_in = ratio_target_ff > RATIO_TARGET_W'(ratio_tol_ff);
      lo_diff    = ratio_target_ff - RATIO_TARGET_W'(ratio_tol_ff);
      hi2_m_in   = H2W'(hi_sum) * H2W'(hi_sum);
      lo2_m_in   = H2W'(lo_diff) * H2W'(lo_diff);
   end

   always_ff @(posedge clock) begin
      if (ld[ST_MUL]) begin
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         pc_ff      <= pc_in;
         pd_ff      <= pd_in;
         la_x_ff    <= la_x_in;
         la_y_ff    <= la_y_in;
         lb_x_ff    <= lb_x_in;
         lb_y_ff    <= lb_y_in;
         hi2_m_ff   <= hi2_m_in;
         lo2_m_ff   <= lo2_m_in;
         lo_en_m_ff <= lo_en_m_in;
      end
   end

   // zero side flags travel with the word up to the rounding stage
   logic [2:0] zf_ff [ST_MUL:ST_ANG-1];

   always_ff @(posedge clock) begin
      if (ld[ST_MUL]) begin
         zf_ff[ST_MUL] <= zf_in;
      end
   end

   for (genvar k = ST_MUL + 1; k <= ST_ANG - 1; k++) begin : g_zf
      always_ff @(posedge clock) begin
         if (ld[k]) begin
            zf_ff[k] <= zf_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- sum stage
   logic signed [SW-1:0] dot_ff [3];
   logic signed [SW-1:0] crs_ff [3];
   logic signed [SW-1:0] dot_in [3];
   logic signed [SW-1:0] crs_in [3];
   logic [LW-1:0]        len_a_ff, len_b_ff, len_a_in, len_b_in;
   logic [H2W-1:0]       hi2_s_ff, lo2_s_ff;
   logic                 lo_en_s_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         dot_in[l] = SW'(pa_ff[l]) + SW'(pb_ff[l]);
         crs_in[l] = SW'(pc_ff[l]) - SW'(pd_ff[l]);
      end
      // squares are never negative, so the low bits hold the whole value
      len_a_in = LW'(la_x_ff) + LW'(la_y_ff);
      len_b_in = LW'(lb_x_ff) + LW'(lb_y_ff);
   end

   always_ff @(posedge clock) begin
      if (ld[ST_SUM]) begin
         dot_ff     <= dot_in;
         crs_ff     <= crs_in;
         len_a_ff   <= len_a_in;
         len_b_ff   <= len_b_in;
         hi2_s_ff   <= hi2_m_ff;
         lo2_s_ff   <= lo2_m_ff;
         lo_en_s_ff <= lo_en_m_ff;
      end
   end

   // ---------------------------------------------------------------- ratio products, angle set-up
   logic [RW-1:0]  lhs_ff, rhs_hi_ff, rhs_lo_ff, lhs_in, rhs_hi_in, rhs_lo_in;
   logic           bnz_ff, lo_en_p_ff;
   logic [MW-1:0]  sx_ff [3];
   logic [MW-1:0]  sy_ff [3];
   logic [MW-1:0]  sx_in [3];
   logic [MW-1:0]  sy_in [3];
   logic           neg_ff [3];
   logic           neg_in [3];

   always_comb begin
      logic signed [SW-1:0] acrs;
      logic signed [SW-1:0] ndot;
      lhs_in    = RW'(len_a_ff) << 16;
      rhs_hi_in = RW'(hi2_s_ff) * RW'(len_b_ff);
      rhs_lo_in = RW'(lo2_s_ff) * RW'(len_b_ff);
      for (int l = 0; l < 3; l++) begin
         acrs = crs_ff[l][SW-1] ? -crs_ff[l] : crs_ff[l];
         ndot = -dot_ff[l];
         // an obtuse corner is turned by 90 degrees first: (dot, |cross|) -> (|cross|, -dot)
         neg_in[l] = dot_ff[l][SW-1];
         if (dot_ff[l][SW-1]) begin
            sx_in[l] = MW'(acrs);
            sy_in[l] = MW'(ndot);
         end else begin
            sx_in[l] = MW'(dot_ff[l]);
            sy_in[l] = MW'(acrs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_PREP]) begin
         lhs_ff     <= lhs_in;
         rhs_hi_ff  <= rhs_hi_in;
         rhs_lo_ff  <= rhs_lo_in;
         bnz_ff     <= len_b_ff != '0;
         lo_en_p_ff <= lo_en_s_ff;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         neg_ff     <= neg_in;
      end
   end

   // ---------------------------------------------------------------- ratio compare, normalise 1
   logic           rok_in;
   logic [NORM_W-1:0] n1x_ff [3];
   logic [NORM_W-1:0] n1y_ff [3];
   logic [NORM_W-1:0] n1x_in [3];
   logic [NORM_W-1:0] n1y_in [3];
   logic           neg1_ff [3];

   always_comb begin
      logic [NORM_W-1:0] m;
      rok_in = bnz_ff && (lhs_ff < rhs_hi_ff) && (!lo_en_p_ff || (lhs_ff > rhs_lo_ff));
      for (int l = 0; l < 3; l++) begin
         n1x_in[l] = NORM_W'(sx_ff[l]);
         n1y_in[l] = NORM_W'(sy_ff[l]);
         m = n1x_in[l] | n1y_in[l];
         if (m[NORM_W-1 -: 32] == '0) begin
            n1x_in[l] = n1x_in[l] << 32;
            n1y_in[l] = n1y_in[l] << 32;
            m         = m << 32;
         end
         if (m[NORM_W-1 -: 16] == '0) begin
            n1x_in[l] = n1x_in[l] << 16;
            n1y_in[l] = n1y_in[l] << 16;
            m         = m << 16;
         end
         if (m[NORM_W-1 -: 8] == '0) begin
            n1x_in[l] = n1x_in[l] << 8;
            n1y_in[l] = n1y_in[l] << 8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_NRM1]) begin
         n1x_ff  <= n1x_in;
         n1y_ff  <= n1y_in;
         neg1_ff <= neg_ff;
      end
   end

   // ratio verdict travels with the word to the output stage
   logic rok_ff [ST_NRM1:ST_ANG];

   always_ff @(posedge clock) begin
      if (ld[ST_NRM1]) begin
         rok_ff[ST_NRM1] <= rok_in;
      end
   end

   for (genvar k = ST_NRM1 + 1; k <= ST_ANG; k++) begin : g_rok
      always_ff @(posedge clock) begin
         if (ld[k]) begin
            rok_ff[k] <= rok_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- normalise 2
   logic [NORM_W-1:0] n2x_ff [3];
   logic [NORM_W-1:0] n2y_ff [3];
   logic [NORM_W-1:0] n2x_in [3];
   logic [NORM_W-1:0] n2y_in [3];
   logic              neg2_ff [3];

   always_comb begin
      logic [NORM_W-1:0] m;
      for (int l = 0; l < 3; l++) begin
         n2x_in[l] = n1x_ff[l];
         n2y_in[l] = n1y_ff[l];
         m = n1x_ff[l] | n1y_ff[l];
         if (m[NORM_W-1 -: 4] == '0) begin
            n2x_in[l] = n2x_in[l] << 4;
            n2y_in[l] = n2y_in[l] << 4;
            m         = m << 4;
         end
         if (m[NORM_W-1 -: 2] == '0) begin
            n2x_in[l] = n2x_in[l] << 2;
            n2y_in[l] = n2y_in[l] << 2;
            m         = m << 2;
         end
         if (!m[NORM_W-1]) begin
            n2x_in[l] = n2x_in[l] << 1;
            n2y_in[l] = n2y_in[l] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_NRM2]) begin
         n2x_ff  <= n2x_in;
         n2y_ff  <= n2y_in;
         neg2_ff <= neg1_ff;
      end
   end

   // ---------------------------------------------------------------- cordic vectoring, one step a stage
   logic signed [XY_W-1:0] cx_ff [CORDIC_STEPS][3];
   logic signed [XY_W-1:0] cy_ff [CORDIC_STEPS][3];
   logic signed [Z_W-1:0]  cz_ff [CORDIC_STEPS][3];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [XY_W-1:0] xs [3];
      logic signed [XY_W-1:0] ys [3];
      logic signed [Z_W-1:0]  zs [3];
      logic signed [XY_W-1:0] xn [3];
      logic signed [XY_W-1:0] yn [3];
      logic signed [Z_W-1:0]  zn [3];

      always_comb begin
         logic signed [Z_W-1:0] at;
         at = $signed(Z_W'(ATAN_Q16[i]));
         for (int l = 0; l < 3; l++) begin
            if (i == 0) begin
               xs[l] = $signed(XY_W'(n2x_ff[l]));
               ys[l] = $signed(XY_W'(n2y_ff[l]));
               zs[l] = neg2_ff[l] ? $signed(Z_RIGHT) : '0;
            end else begin
               xs[l] = cx_ff[(i > 0) ? i - 1 : 0][l];
               ys[l] = cy_ff[(i > 0) ? i - 1 : 0][l];
               zs[l] = cz_ff[(i > 0) ? i - 1 : 0][l];
            end
            // arithmetic shifts round towards minus infinity
            if (!ys[l][XY_W-1]) begin
               xn[l] = xs[l] + (ys[l] >>> i);
               yn[l] = ys[l] - (xs[l] >>> i);
               zn[l] = zs[l] + at;
            end else begin
               xn[l] = xs[l] - (ys[l] >>> i);
               yn[l] = ys[l] + (xs[l] >>> i);
               zn[l] = zs[l] - at;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ld[ST_ROT0 + i]) begin
            cx_ff[i] <= xn;
            cy_ff[i] <= yn;
            cz_ff[i] <= zn;
         end
      end
   end

   // ---------------------------------------------------------------- rounding to degrees q.8
   logic [ANGLE_W-1:0] ang_ff [3];
   logic [ANGLE_W-1:0] ang_in [3];

   always_comb begin
      logic signed [Z_W-1:0] zl;
      logic signed [Z_W-1:0] zr;
      for (int l = 0; l < 3; l++) begin
         zl = cz_ff[CORDIC_STEPS-1][l];
         zr = (zl + Z_W'(128)) >>> 8;
         if (zf_ff[ST_ANG - 1][l]) begin
            ang_in[l] = RIGHT_Q8;
         end else if (zl[Z_W-1]) begin
            ang_in[l] = '0;
         end else if (zr > $signed(Z_W'(STRAIGHT_Q8))) begin
            ang_in[l] = STRAIGHT_Q8;
         end else begin
            ang_in[l] = zr[ANGLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_ANG]) begin
         ang_ff <= ang_in;
      end
   end

   // ---------------------------------------------------------------- angle checks, result word
   localparam int CW = ANGLE_W + 2;

   logic signed [CW-1:0] tq;
   logic signed [CW-1:0] d1, d2, d3;
   logic                 aok;

   always_comb begin
      tq  = $signed(CW'({angle_tol_ff, 8'd0}));
      d1  = $signed(CW'(ang_ff[0])) - $signed(CW'(RIGHT_Q8));
      d2  = $signed(CW'(ang_ff[0])) + $signed(CW'(ang_ff[1])) - $signed(CW'(STRAIGHT_Q8));
      d3  = $signed(CW'(ang_ff[0])) - $signed(CW'(ang_ff[2]));
      aok = (d1 < tq) && (-d1 < tq) && (d2 < tq) && (-d2 < tq) &&
            (d3 < tq) && (-d3 < tq);
   end

   always_ff @(posedge clock) begin
      if (ld[ST_OUT]) begin
         rsp_is_rect     <= rok_ff[ST_ANG] && aok;
         rsp_ratio_ok    <= rok_ff[ST_ANG];
         rsp_angle_at_p1 <= ang_ff[0];
         rsp_angle_at_p2 <= ang_ff[1];
         rsp_angle_at_p3 <= ang_ff[2];
      end
   end

   // ---------------------------------------------------------------- assertions
   a_rect_needs_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_rect |-> rsp_ratio_ok)
      else $error("rectangle reported without a passing ratio");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_at_p1 <= STRAIGHT_Q8) && (rsp_angle_at_p2 <= STRAIGHT_Q8) &&
                    (rsp_angle_at_p3 <= STRAIGHT_Q8))
      else $error("corner angle above 180 degrees");

   a_full_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && rsp_stall |-> req_stall)
      else $error("input taken while the full pipeline is stalled");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_angle_at_p1) && $stable(rsp_is_rect))
      else $error("stalled result word changed");

endmodule
